/* design/pdlf_pkg.sv */
// Shared constants and types for the PD line-follower step block.
package pdlf_pkg;

  localparam int SENS_W     = 16;
  localparam int GAIN_P_W   = 10;
  localparam int GAIN_D_W   = 12;
  localparam int SPEED_W    = 8;
  localparam int FRAC_W     = 8;
  localparam int NUM_W      = SENS_W + FRAC_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam int ERR_W      = SENS_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int PROD_P_W   = GAIN_P_W + 1 + ERR_W;
  localparam int PROD_D_W   = GAIN_D_W + 1 + DIFF_W;
  localparam int DRIVE_W    = 32;
  localparam int SUM_W      = DRIVE_W + 1;
  localparam int ARM_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ARM_W-1:0] ARM_STEPS = 7'd100;

  localparam logic [SENS_W-1:0]    RST_BLACK_LEVEL     = 16'd23999;
  localparam logic [SENS_W-1:0]    RST_OUTER_MARGIN    = 16'd5000;
  localparam logic [SENS_W-1:0]    RST_ALL_BLACK_LEVEL = 16'd22000;
  localparam logic [GAIN_P_W-1:0]  RST_GAIN_P          = 10'd85;
  localparam logic [GAIN_D_W-1:0]  RST_GAIN_D          = 12'd600;
  localparam logic [SPEED_W-1:0]   RST_CRUISE_SPEED    = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHITE_LEFT      = 3'd0,
    CFG_WHITE_RIGHT     = 3'd1,
    CFG_BLACK_LEVEL     = 3'd2,
    CFG_OUTER_MARGIN    = 3'd3,
    CFG_ALL_BLACK_LEVEL = 3'd4,
    CFG_GAIN_P          = 3'd5,
    CFG_GAIN_D          = 3'd6,
    CFG_CRUISE_SPEED    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic load_in;
    logic div_step;
    logic calc_err;
    logic calc_mul;
    logic calc_drive;
    logic load_out;
  } pdlf_cmd_t;

endpackage

/* design/pdlf_in_if.sv */
// Input channel carrying one reading of the four reflectance sensors.
interface pdlf_in_if
  import pdlf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SENS_W-1:0] outer_left;
  logic [SENS_W-1:0] inner_left;
  logic [SENS_W-1:0] inner_right;
  logic [SENS_W-1:0] outer_right;

  modport source (output valid, outer_left, inner_left, inner_right, outer_right,
                  input ready);
  modport sink (input valid, outer_left, inner_left, inner_right, outer_right,
                output ready);
endinterface

/* design/pdlf_out_if.sv */
// Output channel carrying one motor command.
interface pdlf_out_if
  import pdlf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic               left_reverse;
  logic               right_reverse;
  logic               finish_seen;

  modport source (output valid, left_speed, right_speed, left_reverse, right_reverse,
                  finish_seen, input ready);
  modport sink (input valid, left_speed, right_speed, left_reverse, right_reverse,
                finish_seen, output ready);
endinterface

/* design/pdlf_div.sv */
// Radix-2 restoring divider giving a saturated Q8.8 ratio, one quotient bit per cycle while step is high.
module pdlf_div
  import pdlf_pkg::*;
(
  input  logic              clk,
  input  logic              init,
  input  logic              step,
  input  logic [NUM_W-1:0]  num,
  input  logic [SENS_W-1:0] den,
  output logic [SENS_W-1:0] quo
);

  logic [SENS_W-1:0] den_r;
  logic [SENS_W-1:0] rem;
  logic [NUM_W-1:0]  sh;
  logic [SENS_W:0]   trial;
  logic [SENS_W:0]   sub;
  logic              ge;

  assign trial = {rem, sh[NUM_W-1]};
  assign sub   = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (init) begin
      den_r <= den;
      rem   <= '0;
      sh    <= num;
    end else if (step) begin
      rem <= ge ? sub[SENS_W-1:0] : trial[SENS_W-1:0];
      sh  <= {sh[NUM_W-2:0], ge};
    end
  end

  assign quo = (|sh[NUM_W-1:SENS_W]) ? {SENS_W{1'b1}} : sh[SENS_W-1:0];

endmodule

/* design/pdlf_ctrl.sv */
// Controller state machine sequencing the division, PD and output steps.
module pdlf_ctrl
  import pdlf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output pdlf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ERR,
    S_MUL,
    S_DRIVE,
    S_WRITE
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [STEP_CNT_W-1:0] cnt;
  logic [STEP_CNT_W-1:0] cnt_next;
  logic                  in_ready_next;
  logic                  out_valid_next;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_ready ? 1'b0 : out_valid;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          cnt_next    = '0;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = S_DRIVE;
      end
      S_DRIVE: begin
        cmd.calc_drive = 1'b1;
        state_next     = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    in_ready_next = (state_next == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      in_ready  <= in_ready_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/pdlf_dp.sv */
// Datapath: configuration registers, ratio dividers, PD arithmetic and output register.
module pdlf_dp
  import pdlf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pdlf_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SENS_W-1:0]     in_outer_left,
  input  logic [SENS_W-1:0]     in_inner_left,
  input  logic [SENS_W-1:0]     in_inner_right,
  input  logic [SENS_W-1:0]     in_outer_right,
  output logic [SPEED_W-1:0]    left_speed,
  output logic [SPEED_W-1:0]    right_speed,
  output logic                  left_reverse,
  output logic                  right_reverse,
  output logic                  finish_seen
);

  logic [SENS_W-1:0]   white_left;
  logic [SENS_W-1:0]   white_right;
  logic [SENS_W-1:0]   black_level;
  logic [SENS_W-1:0]   outer_margin;
  logic [SENS_W-1:0]   all_black_level;
  logic [GAIN_P_W-1:0] gain_p;
  logic [GAIN_D_W-1:0] gain_d;
  logic [SPEED_W-1:0]  cruise_speed;

  logic [SENS_W-1:0] ol;
  logic [SENS_W-1:0] il;
  logic [SENS_W-1:0] ir;
  logic [SENS_W-1:0] orr;

  logic [SENS_W:0]     diff_l;
  logic [SENS_W:0]     diff_r;
  logic [SENS_W-1:0]   den_l;
  logic [SENS_W-1:0]   den_r;
  logic [NUM_W-1:0]    num;
  logic [SENS_W-1:0]   q_l;
  logic [SENS_W-1:0]   q_r;

  logic signed [ERR_W-1:0]    err_c;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    prev_err;
  logic signed [DIFF_W-1:0]   derr;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [DRIVE_W-1:0]  drive;
  logic [ARM_W-1:0]           arm_cnt;

  logic signed [SUM_W-1:0] base_q;
  logic signed [SUM_W-1:0] sum_l;
  logic signed [SUM_W-1:0] sum_r;
  logic [SPEED_W-1:0]      sp_l;
  logic [SPEED_W-1:0]      sp_r;
  logic [SPEED_W-1:0]      fs_l;
  logic [SPEED_W-1:0]      fs_r;
  logic signed [SENS_W:0]  thr;
  logic                    all_black;
  logic                    trig_r;
  logic                    trig_l;

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] s);
    logic [SPEED_W-1:0] r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|s[SUM_W-2:FRAC_W+SPEED_W]) begin
      r = {SPEED_W{1'b1}};
    end else begin
      r = s[FRAC_W+SPEED_W-1:FRAC_W];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      white_left      <= '0;
      white_right     <= '0;
      black_level     <= RST_BLACK_LEVEL;
      outer_margin    <= RST_OUTER_MARGIN;
      all_black_level <= RST_ALL_BLACK_LEVEL;
      gain_p          <= RST_GAIN_P;
      gain_d          <= RST_GAIN_D;
      cruise_speed    <= RST_CRUISE_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WHITE_LEFT:      white_left      <= cfg_data;
        CFG_WHITE_RIGHT:     white_right     <= cfg_data;
        CFG_BLACK_LEVEL:     black_level     <= cfg_data;
        CFG_OUTER_MARGIN:    outer_margin    <= cfg_data;
        CFG_ALL_BLACK_LEVEL: all_black_level <= cfg_data;
        CFG_GAIN_P:          gain_p          <= cfg_data[GAIN_P_W-1:0];
        CFG_GAIN_D:          gain_d          <= cfg_data[GAIN_D_W-1:0];
        CFG_CRUISE_SPEED:    cruise_speed    <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // An inner reading at or below its white level clips the denominator to one.
  assign diff_l = {1'b0, in_inner_left} - {1'b0, white_left};
  assign diff_r = {1'b0, in_inner_right} - {1'b0, white_right};
  assign den_l  = (diff_l[SENS_W] || diff_l == '0) ? SENS_W'(1) : diff_l[SENS_W-1:0];
  assign den_r  = (diff_r[SENS_W] || diff_r == '0) ? SENS_W'(1) : diff_r[SENS_W-1:0];
  assign num    = {black_level, {FRAC_W{1'b0}}};

  pdlf_div u_div_l (
    .clk  (clk),
    .init (cmd.load_in),
    .step (cmd.div_step),
    .num  (num),
    .den  (den_l),
    .quo  (q_l)
  );

  pdlf_div u_div_r (
    .clk  (clk),
    .init (cmd.load_in),
    .step (cmd.div_step),
    .num  (num),
    .den  (den_r),
    .quo  (q_r)
  );

  assign err_c = $signed({1'b0, q_l}) - $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ol  <= in_outer_left;
      il  <= in_inner_left;
      ir  <= in_inner_right;
      orr <= in_outer_right;
    end
    if (cmd.calc_err) begin
      err  <= err_c;
      derr <= DIFF_W'(err_c) - DIFF_W'(prev_err);
    end
    if (cmd.calc_mul) begin
      prod_p <= $signed({1'b0, gain_p}) * err;
      prod_d <= $signed({1'b0, gain_d}) * derr;
    end
    if (cmd.calc_drive) begin
      drive <= DRIVE_W'(prod_p) + DRIVE_W'(prod_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      arm_cnt  <= '0;
    end else begin
      if (cmd.calc_err) begin
        prev_err <= err_c;
      end
      if (cmd.load_out && arm_cnt < ARM_STEPS) begin
        arm_cnt <= arm_cnt + 1'b1;
      end
    end
  end

  assign base_q = $signed({1'b0, cruise_speed, {FRAC_W{1'b0}}});
  assign sum_l  = base_q + SUM_W'(drive);
  assign sum_r  = base_q - SUM_W'(drive);
  assign sp_l   = clamp_speed(sum_l);
  assign sp_r   = clamp_speed(sum_r);

  // The wheel that would run faster is driven at full speed.
  always_comb begin
    fs_l = sp_l;
    fs_r = sp_r;
    if (sp_r < sp_l) begin
      fs_l = {SPEED_W{1'b1}};
    end else if (sp_l < sp_r) begin
      fs_r = {SPEED_W{1'b1}};
    end
  end

  assign thr       = $signed({1'b0, black_level}) - $signed({1'b0, outer_margin});
  assign all_black = (ol > all_black_level) && (il > all_black_level) &&
                     (ir > all_black_level) && (orr > all_black_level);
  assign trig_r    = ($signed({1'b0, orr}) >= thr) && !all_black;
  assign trig_l    = ($signed({1'b0, ol}) >= thr) && !all_black;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      finish_seen <= all_black && (arm_cnt >= ARM_STEPS);
      if (trig_r) begin
        left_speed    <= {SPEED_W{1'b1}};
        right_speed   <= {SPEED_W{1'b1}};
        left_reverse  <= 1'b0;
        right_reverse <= 1'b1;
      end else if (trig_l) begin
        left_speed    <= {SPEED_W{1'b1}};
        right_speed   <= {SPEED_W{1'b1}};
        left_reverse  <= 1'b1;
        right_reverse <= 1'b0;
      end else begin
        left_speed    <= fs_l;
        right_speed   <= fs_r;
        left_reverse  <= 1'b0;
        right_reverse <= 1'b0;
      end
    end
  end

endmodule

/* design/pd_line_follow_step_top.sv */
// Top level of the PD line-follower step block.
// Each transfer on in_ch is one reading of the four reflectance sensors and yields exactly one
// motor command on out_ch. After its transfer, an item runs through the two restoring dividers
// that form the left and right Q8.8 ratios side by side, one quotient bit per cycle, then
// through the steps for the error, the gain multiplications, the drive sum and the output
// register, which waits until out_ch is free, and back to idle, where the next transfer is taken.
// The command appears on out_ch from the output register; no new item is taken before that.
// The output register lets the next item be taken while the previous command still waits on
// out_ch; that next item then holds in its output step until out_ch is free. Configuration
// writes through cfg_we, cfg_index and cfg_data take effect in the next cycle and belong
// in idle periods only.
module pd_line_follow_step_top
  import pdlf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pdlf_in_if.sink               in_ch,
  pdlf_out_if.source            out_ch
);

  pdlf_cmd_t cmd;

  pdlf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  pdlf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_outer_left  (in_ch.outer_left),
    .in_inner_left  (in_ch.inner_left),
    .in_inner_right (in_ch.inner_right),
    .in_outer_right (in_ch.outer_right),
    .left_speed     (out_ch.left_speed),
    .right_speed    (out_ch.right_speed),
    .left_reverse   (out_ch.left_reverse),
    .right_reverse  (out_ch.right_reverse),
    .finish_seen    (out_ch.finish_seen)
  );

endmodule

/* bench/pd_line_follow_step_top_test.sv */
// Self-checking testbench for the PD line-follower step block, compared against a local predictor.
module pd_line_follow_step_top_test;
  import pdlf_pkg::*;

  typedef struct packed {
    logic [SENS_W-1:0] outer_left;
    logic [SENS_W-1:0] inner_left;
    logic [SENS_W-1:0] inner_right;
    logic [SENS_W-1:0] outer_right;
  } reading_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               left_reverse;
    logic               right_reverse;
    logic               finish_seen;
  } motor_cmd_t;

  typedef struct {
    reading_t   rd;
    bit         typed;
    motor_cmd_t cmd;
  } drill_row_t;

  typedef struct {
    logic [SENS_W-1:0]   white_left;
    logic [SENS_W-1:0]   white_right;
    logic [SENS_W-1:0]   black_level;
    logic [SENS_W-1:0]   outer_margin;
    logic [SENS_W-1:0]   all_black_level;
    logic [GAIN_P_W-1:0] gain_p;
    logic [GAIN_D_W-1:0] gain_d;
    logic [SPEED_W-1:0]  cruise_speed;
  } setup_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdlf_in_if  in_ch();
  pdlf_out_if out_ch();

  pd_line_follow_step_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Local copy of the registers and the steering state.
  logic [SENS_W-1:0]   wl_cal     = '0;
  logic [SENS_W-1:0]   wr_cal     = '0;
  logic [SENS_W-1:0]   blk_lvl    = RST_BLACK_LEVEL;
  logic [SENS_W-1:0]   out_margin = RST_OUTER_MARGIN;
  logic [SENS_W-1:0]   allblk_lvl = RST_ALL_BLACK_LEVEL;
  logic [GAIN_P_W-1:0] kp         = RST_GAIN_P;
  logic [GAIN_D_W-1:0] kd         = RST_GAIN_D;
  logic [SPEED_W-1:0]  base_spd   = RST_CRUISE_SPEED;
  int                  last_error = 0;
  int                  arm_steps  = 0;

  motor_cmd_t pending_cmds[$];
  int         mismatches  = 0;
  int         items_sent  = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         hold_req    = 0;
  bit         typed_now   = 1'b0;
  motor_cmd_t typed_cmd   = '0;

  int tx_modes[4] = '{0, 79, 0, 36};
  int rx_modes[4] = '{0, 0, 79, 36};

  drill_row_t drill[16] = '{
    '{'{16'd0,     16'd0,     16'd0,     16'd0    }, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b0, 1'b0}},
    '{'{16'd0,     16'd0,     16'd0,     16'hFFFF }, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b1, 1'b0}},
    '{'{16'hFFFF,  16'd0,     16'd0,     16'd0    }, 1'b1, '{8'd255, 8'd255, 1'b1, 1'b0, 1'b0}},
    '{'{16'hFFFF,  16'd0,     16'd0,     16'hFFFF }, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b1, 1'b0}},
    '{'{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF }, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b0, 1'b0}},
    '{'{16'd0,     16'hFFFF,  16'd0,     16'd0    }, 1'b0, '0},
    '{'{16'd0,     16'd0,     16'hFFFF,  16'd0    }, 1'b0, '0},
    '{'{16'd100,   16'd1000,  16'd2000,  16'd100  }, 1'b0, '0},
    '{'{16'd100,   16'd24000, 16'd23999, 16'd100  }, 1'b0, '0},
    '{'{16'd100,   16'd12000, 16'd48000, 16'd100  }, 1'b0, '0},
    '{'{16'd22000, 16'd22000, 16'd22000, 16'd22000}, 1'b0, '0},
    '{'{16'd22001, 16'd22001, 16'd22001, 16'd22001}, 1'b0, '0},
    '{'{16'd100,   16'd100,   16'd100,   16'd18999}, 1'b0, '0},
    '{'{16'd18999, 16'd300,   16'd300,   16'd18998}, 1'b0, '0},
    '{'{16'd0,     16'd300,   16'd300,   16'd0    }, 1'b0, '0},
    '{'{16'd0,     16'd5000,  16'd800,   16'd0    }, 1'b0, '0}
  };

  setup_t plan[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SENS_W-1:0] sat16(int v);
    if (v > 65535) return 16'hFFFF;
    if (v < 0) return '0;
    return v[SENS_W-1:0];
  endfunction

  function automatic int q88_ratio(logic [SENS_W-1:0] reading, logic [SENS_W-1:0] white);
    int     den;
    longint q;
    den = int'(reading) - int'(white);
    if (den < 1) den = 1;
    q = (longint'(blk_lvl) << FRAC_W) / den;
    return (q > 65535) ? 65535 : int'(q);
  endfunction

  function automatic logic [SPEED_W-1:0] wheel_duty(longint s);
    if (s < 0) return '0;
    s = s >>> FRAC_W;
    if (s > 255) return 8'd255;
    return s[SPEED_W-1:0];
  endfunction

  function automatic motor_cmd_t steer_command(reading_t rd);
    motor_cmd_t c;
    int         err;
    int         thr;
    longint     drive;
    longint     base;
    bit         all_black;
    c = '0;
    err = q88_ratio(rd.inner_left, wl_cal) - q88_ratio(rd.inner_right, wr_cal);
    drive = longint'(kp) * err + longint'(kd) * (longint'(err) - last_error);
    base = longint'(base_spd) * 256;
    c.left_speed = wheel_duty(base + drive);
    c.right_speed = wheel_duty(base - drive);
    thr = int'(blk_lvl) - int'(out_margin);
    all_black = rd.outer_left > allblk_lvl && rd.inner_left > allblk_lvl &&
                rd.inner_right > allblk_lvl && rd.outer_right > allblk_lvl;
    last_error = err;
    if (c.right_speed < c.left_speed) begin
      c.left_speed = 8'd255;
    end else if (c.left_speed < c.right_speed) begin
      c.right_speed = 8'd255;
    end
    if (int'(rd.outer_right) >= thr && !all_black) begin
      c.right_reverse = 1'b1;
      c.left_speed = 8'd255;
      c.right_speed = 8'd255;
    end else if (int'(rd.outer_left) >= thr && !all_black) begin
      c.left_reverse = 1'b1;
      c.left_speed = 8'd255;
      c.right_speed = 8'd255;
    end
    c.finish_seen = all_black && arm_steps >= int'(ARM_STEPS);
    if (arm_steps < int'(ARM_STEPS)) arm_steps++;
    return c;
  endfunction

  function automatic reading_t draw_reading(bit force_black);
    reading_t          rd;
    logic [SENS_W-1:0] corner;
    int                thr;
    int                pick;
    int                k;
    thr = int'(blk_lvl) - int'(out_margin);
    pick = force_black ? 55 : int'($urandom_range(99));
    rd.outer_left = SENS_W'($urandom_range(65535));
    rd.inner_left = SENS_W'($urandom_range(65535));
    rd.inner_right = SENS_W'($urandom_range(65535));
    rd.outer_right = SENS_W'($urandom_range(65535));
    if (pick >= 84) begin
      for (k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0: corner = '0;
          1: corner = 16'hFFFF;
          2: corner = 16'd1;
          default: corner = SENS_W'($urandom_range(65535));
        endcase
        rd[k*SENS_W +: SENS_W] = corner;
      end
    end else if (pick >= 62 && pick < 72) begin
      rd.inner_left = SENS_W'($urandom_range(int'(wl_cal), 0));
      if ($urandom_range(1)) rd.inner_right = SENS_W'($urandom_range(int'(wr_cal), 0));
    end else if (pick >= 50 && pick < 62) begin
      if (allblk_lvl != 16'hFFFF) begin
        rd.outer_left = SENS_W'($urandom_range(65535, int'(allblk_lvl) + 1));
        rd.inner_left = SENS_W'($urandom_range(65535, int'(allblk_lvl) + 1));
        rd.inner_right = SENS_W'($urandom_range(65535, int'(allblk_lvl) + 1));
        rd.outer_right = SENS_W'($urandom_range(65535, int'(allblk_lvl) + 1));
      end
    end else if (pick >= 15) begin
      // A reading near the line: inner sensors a little above white, outers off the line, or one outer on it.
      rd.inner_left = sat16(int'(wl_cal) + int'($urandom_range(3000, 1)));
      rd.inner_right = sat16(int'(wr_cal) + int'($urandom_range(3000, 1)));
      if (thr > 0) begin
        rd.outer_left = SENS_W'($urandom_range(thr - 1, 0));
        rd.outer_right = SENS_W'($urandom_range(thr - 1, 0));
      end
      if (pick >= 72) begin
        if ($urandom_range(1)) begin
          rd.outer_right = SENS_W'($urandom_range(65535, (thr < 0) ? 0 : thr));
        end else begin
          rd.outer_left = SENS_W'($urandom_range(65535, (thr < 0) ? 0 : thr));
        end
      end
    end
    return rd;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 100) begin
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    motor_cmd_t got;
    motor_cmd_t want;
    reading_t   rd;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.left_speed, out_ch.right_speed, out_ch.left_reverse,
                out_ch.right_reverse, out_ch.finish_seen};
        if (pending_cmds.size() == 0) begin
          report_mismatch("unrequested command", 1, 0);
        end else begin
          want = pending_cmds.pop_front();
          if (got.left_speed != want.left_speed)
            report_mismatch("left_speed", got.left_speed, want.left_speed);
          if (got.right_speed != want.right_speed)
            report_mismatch("right_speed", got.right_speed, want.right_speed);
          if (got.left_reverse != want.left_reverse)
            report_mismatch("left_reverse", got.left_reverse, want.left_reverse);
          if (got.right_reverse != want.right_reverse)
            report_mismatch("right_reverse", got.right_reverse, want.right_reverse);
          if (got.finish_seen != want.finish_seen)
            report_mismatch("finish_seen", got.finish_seen, want.finish_seen);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        rd = '{in_ch.outer_left, in_ch.inner_left, in_ch.inner_right, in_ch.outer_right};
        want = steer_command(rd);
        if (typed_now) want = typed_cmd;
        pending_cmds.push_back(want);
      end
    end
  end

  initial begin : sink_side
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_req) begin
        holds_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WHITE_LEFT:      wl_cal = val;
      CFG_WHITE_RIGHT:     wr_cal = val;
      CFG_BLACK_LEVEL:     blk_lvl = val;
      CFG_OUTER_MARGIN:    out_margin = val;
      CFG_ALL_BLACK_LEVEL: allblk_lvl = val;
      CFG_GAIN_P:          kp = val[GAIN_P_W-1:0];
      CFG_GAIN_D:          kd = val[GAIN_D_W-1:0];
      CFG_CRUISE_SPEED:    base_spd = val[SPEED_W-1:0];
    endcase
  endtask

  task automatic apply_setup(setup_t s);
    write_reg(CFG_WHITE_LEFT, s.white_left);
    write_reg(CFG_WHITE_RIGHT, s.white_right);
    write_reg(CFG_BLACK_LEVEL, s.black_level);
    write_reg(CFG_OUTER_MARGIN, s.outer_margin);
    write_reg(CFG_ALL_BLACK_LEVEL, s.all_black_level);
    write_reg(CFG_GAIN_P, CFG_DATA_W'(s.gain_p));
    write_reg(CFG_GAIN_D, CFG_DATA_W'(s.gain_d));
    write_reg(CFG_CRUISE_SPEED, CFG_DATA_W'(s.cruise_speed));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  task automatic offer(reading_t rd, bit typed, motor_cmd_t cmd);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.outer_left <= rd.outer_left;
    in_ch.inner_left <= rd.inner_left;
    in_ch.inner_right <= rd.inner_right;
    in_ch.outer_right <= rd.outer_right;
    typed_now <= typed;
    typed_cmd <= cmd;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int p;
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_WHITE_LEFT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.outer_left = '0;
    in_ch.inner_left = '0;
    in_ch.inner_right = '0;
    in_ch.outer_right = '0;
    plan[0] = '{16'd300, 16'd350, 16'd23999, 16'd5000, 16'd22000, 10'd85, 12'd600, 8'd200};
    plan[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 10'd1023, 12'd4095, 8'd255};
    plan[2] = '{16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 10'd0, 12'd0, 8'd0};
    plan[3] = '{16'd1000, 16'd2000, 16'd12000, 16'd3000, 16'd20000, 10'd512, 12'd2048, 8'd128};
    plan[4] = '{16'd0, 16'd0, 16'hFFFF, 16'd20000, 16'd30000, 10'd1023, 12'd0, 8'd100};
    plan[5] = '{16'd5000, 16'd5000, 16'd40000, 16'd1000, 16'd50000, 10'd0, 12'd4095, 8'd255};
    for (p = 6; p < 8; p++) begin
      plan[p] = '{SENS_W'($urandom_range(65535)), SENS_W'($urandom_range(65535)),
                  SENS_W'($urandom_range(65535)), SENS_W'($urandom_range(65535)),
                  SENS_W'($urandom_range(65535)), GAIN_P_W'($urandom_range(1023)),
                  GAIN_D_W'($urandom_range(4095)), SPEED_W'($urandom_range(255))};
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (drill[i]) offer(drill[i].rd, drill[i].typed, drill[i].cmd);
    drain();

    for (p = 0; p < 8; p++) begin
      apply_setup(plan[p]);
      tx_idle_pct <= tx_modes[p % 4];
      rx_stall_pct <= rx_modes[p % 4];
      // The receiver holds off for a long stretch here while readings keep coming.
      if (p == 4) hold_req <= hold_req + 1;
      n = (p == 0) ? 100 : 75;
      repeat (n) begin
        sender_gap();
        // The steps just before and after arming completes see all black.
        offer(draw_reading(items_sent == 99 || items_sent == 100), 1'b0, '0);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
